FILE: rtl/gscc_pkg.sv
// ----------------------------------------------------------------------------
// Grid spanning cluster counter package
// Shared constants, register indexes, state codes and interface structs.
// ----------------------------------------------------------------------------
package gscc_pkg;

  localparam int unsigned MAX_SITES   = 63;
  localparam int unsigned OCC_W       = 63;
  localparam int unsigned DIM_W       = 6;
  localparam int unsigned SITES_W     = 2 * DIM_W;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned TALLY_W     = 60;
  localparam int unsigned HIST_DEPTH  = 64;
  localparam int unsigned HIST_AW     = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0]   COLUMNS_RESET = DIM_W'(4);
  localparam logic [DIM_W-1:0]   ROWS_RESET    = DIM_W'(4);
  localparam logic [TALLY_W-1:0] TALLY_MAX     = {TALLY_W{1'b1}};

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWEEP  = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_READ   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_OUT    = 6'b100000
  } gscc_state_e;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [HIST_AW-1:0] addr;
  } hist_req_t;

  typedef struct packed {
    logic done;
    logic spans;
  } flood_res_t;

endpackage

FILE: rtl/gscc_flood.sv
// ----------------------------------------------------------------------------
// Flood fill unit
// Grows the set of sites reached from the top row by one neighbor step per
// cycle through a shared shift network until it stops changing.
// ----------------------------------------------------------------------------
module gscc_flood (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gscc_pkg::OCC_W-1:0]  occ_i,
  input  logic [gscc_pkg::OCC_W-1:0]  left_edge_i,
  input  logic [gscc_pkg::OCC_W-1:0]  right_edge_i,
  input  logic [gscc_pkg::DIM_W-1:0]  cols_i,
  input  logic [gscc_pkg::DIM_W-1:0]  sites_i,
  output gscc_pkg::flood_res_t        res_o
);
  import gscc_pkg::*;

  logic             busy_q, busy_d;
  logic [OCC_W-1:0] reach_q, reach_d;
  logic [OCC_W-1:0] top_mask, bottom_mask, next_reach;
  logic [DIM_W-1:0] bottom_start;

  assign bottom_start = sites_i - cols_i;

  always_comb begin
    for (int i = 0; i < OCC_W; i++) begin
      top_mask[i]    = (DIM_W'(i) < cols_i);
      bottom_mask[i] = (DIM_W'(i) >= bottom_start) && (DIM_W'(i) < sites_i);
    end
  end

  always_comb begin
    next_reach = (reach_q
                 | ((reach_q & ~right_edge_i) << 1)
                 | ((reach_q & ~left_edge_i) >> 1)
                 | (reach_q << cols_i)
                 | (reach_q >> cols_i)) & occ_i;
  end

  assign res_o.done  = busy_q && (next_reach == reach_q);
  assign res_o.spans = |(reach_q & bottom_mask);

  always_comb begin
    busy_d  = busy_q;
    reach_d = reach_q;
    if (start_i) begin
      busy_d  = 1'b1;
      reach_d = occ_i & top_mask;
    end else if (busy_q) begin
      reach_d = next_reach;
      if (next_reach == reach_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      reach_q <= '0;
    end else begin
      busy_q  <= busy_d;
      reach_q <= reach_d;
    end
  end

endmodule

FILE: rtl/gscc_hist.sv
// ----------------------------------------------------------------------------
// Histogram memory
// One entry per occupied-site count, with a valid bit per entry so that the
// whole table reads as zero right after reset. Read data is registered.
// ----------------------------------------------------------------------------
module gscc_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gscc_pkg::hist_req_t           req_i,
  input  logic [gscc_pkg::TALLY_W-1:0]  wr_data_i,
  output logic [gscc_pkg::TALLY_W-1:0]  rd_data_o
);
  import gscc_pkg::*;

  logic [TALLY_W-1:0]    mem_q [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid_q;
  logic [TALLY_W-1:0]    rd_data_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: rtl/grid_spanning_cluster_counter.sv
// ----------------------------------------------------------------------------
// Grid spanning cluster counter
// Decides whether an occupancy mask spans the grid from top to bottom, counts
// occupied sites and keeps a saturating histogram of spanning masks.
// ----------------------------------------------------------------------------
// The edge and count sweep visits the sites in order, and the flood unit then
// grows the reached set one neighbor step at a time until it stops changing.
// An oversized grid skips to the output, an empty grid to the histogram read.
// Throughput: one request at a time; the next request is taken once the
// result is in the output register. Reset clears the histogram at once
// through per-entry valid bits and restores a 4 by 4 grid.
// ----------------------------------------------------------------------------
module grid_spanning_cluster_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // occupancy [62:0], zero pad [63]
  input  logic [gscc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // spans [0], occupied_sites [6:1], tally [66:7], size_error [67], zero pad
  output logic [gscc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gscc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gscc_pkg::DIM_W-1:0]        cfg_data_i
);
  import gscc_pkg::*;

  gscc_state_e        state_q, state_d;
  logic [DIM_W-1:0]   cols_q, rows_q;
  logic [DIM_W-1:0]   sites_q;
  logic [OCC_W-1:0]   occ_q, left_q, right_q;
  logic [DIM_W-1:0]   idx_q, col_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               spans_q, err_q;
  logic [TALLY_W-1:0] tally_q;
  logic               out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [SITES_W-1:0] sites_full;
  logic [OCC_W-1:0]   grid_mask;
  logic               in_accept, last_site, flood_start;
  logic [TALLY_W-1:0] hist_rd, tally_new;
  logic               tally_inc;
  hist_req_t          hist_req;
  flood_res_t         flood_res;

  assign sites_full = SITES_W'(cols_q) * SITES_W'(rows_q);

  always_comb begin
    for (int i = 0; i < OCC_W; i++) begin
      grid_mask[i] = (SITES_W'(i) < sites_full);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign last_site     = (idx_q == sites_q - DIM_W'(1));
  assign flood_start   = (state_q == ST_SWEEP) && last_site;

  assign tally_inc = spans_q && (hist_rd != TALLY_MAX);
  assign tally_new = tally_inc ? hist_rd + TALLY_W'(1) : hist_rd;

  assign hist_req.rd_en = (state_q == ST_READ);
  assign hist_req.wr_en = (state_q == ST_UPDATE) && tally_inc;
  assign hist_req.addr  = HIST_AW'(cnt_q);

  gscc_flood u_flood (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (flood_start),
    .occ_i        (occ_q),
    .left_edge_i  (left_q),
    .right_edge_i (right_q),
    .cols_i       (cols_q),
    .sites_i      (sites_q),
    .res_o        (flood_res)
  );

  gscc_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hist_req),
    .wr_data_i (tally_new),
    .rd_data_o (hist_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (sites_full > SITES_W'(MAX_SITES)) begin
            state_d = ST_OUT;
          end else if (sites_full == '0) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (last_site) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (flood_res.done) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cols_q      <= COLUMNS_RESET;
      rows_q      <= ROWS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_COLUMNS) begin
          cols_q <= cfg_data_i;
        end else if (cfg_index_i == REG_ROWS) begin
          rows_q <= cfg_data_i;
        end
      end
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          occ_q   <= s_axis_tdata[OCC_W-1:0] & grid_mask;
          left_q  <= '0;
          right_q <= '0;
          sites_q <= sites_full[DIM_W-1:0];
          idx_q   <= '0;
          col_q   <= '0;
          cnt_q   <= '0;
          spans_q <= 1'b0;
          tally_q <= '0;
          err_q   <= (sites_full > SITES_W'(MAX_SITES));
        end
      end
      ST_SWEEP: begin
        cnt_q          <= cnt_q + CNT_W'(occ_q[idx_q]);
        left_q[idx_q]  <= (col_q == '0);
        right_q[idx_q] <= (col_q == cols_q - DIM_W'(1));
        col_q          <= (col_q == cols_q - DIM_W'(1)) ? '0 : col_q + DIM_W'(1);
        idx_q          <= idx_q + DIM_W'(1);
      end
      ST_FILL: begin
        if (flood_res.done) begin
          spans_q <= flood_res.spans;
        end
      end
      ST_UPDATE: begin
        tally_q <= tally_new;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {4'b0000, err_q, tally_q, cnt_q, spans_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/gscc_checker.sv
// ----------------------------------------------------------------------------
// Grid spanning cluster counter checker
// Port-level properties of the counter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gscc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic [gscc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [gscc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);
  import gscc_pkg::*;

  a_error_clears_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[67]) |-> (m_axis_tdata[66:0] == '0))
    else $error("size error result carries nonzero fields");

  a_span_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      (m_axis_tdata[6:1] != '0) && (m_axis_tdata[66:7] != '0))
    else $error("spanning result without occupied sites or tally");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind grid_spanning_cluster_counter gscc_checker u_gscc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

FILE: test/tb_grid_spanning_cluster_counter.sv
// ----------------------------------------------------------------------------
// Grid spanning cluster counter testbench
// Sends occupancy masks over many grid shapes and checks every response
// against a cycle-free model of the flood fill and the spanning histogram,
// or against the row's result for typed table rows. Directed requests come
// first; three random phases follow with different backpressure on each side.
// ----------------------------------------------------------------------------
module tb_grid_spanning_cluster_counter;
  import gscc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 140;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic               size_error;
    logic [TALLY_W-1:0] tally;
    logic [CNT_W-1:0]   occupied;
    logic               spans;
  } span_result_t;

  typedef enum logic {ROW_MASK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DIM_W-1:0]     reg_val;
    logic [OCC_W-1:0]     mask;
    logic                 typed;
    span_result_t         want;
  } dir_row_t;

  localparam logic [OCC_W-1:0] ALL_SITES = {OCC_W{1'b1}};
  localparam span_result_t     NO_SPAN   = '0;
  localparam span_result_t     OVERSIZE  = '{1'b1, 60'd0, 6'd0, 1'b0};

  localparam int unsigned DIR_ROWS = 27;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'd0,      1'b1, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  ALL_SITES,  1'b1, '{1'b0, 60'd1, 6'd16, 1'b1}},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h1111,   1'b1, '{1'b0, 60'd1, 6'd4, 1'b1}},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h000F,   1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h8421,   1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h1118,   1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'hF000,   1'b0, NO_SPAN},
    '{ROW_REG,  REG_COLUMNS, 6'd63, 63'd0,      1'b0, NO_SPAN},
    '{ROW_REG,  REG_ROWS,    6'd1,  63'd0,      1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h4000_0000_0000_0000, 1'b1,
      '{1'b0, 60'd1, 6'd1, 1'b1}},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'd0,      1'b1, NO_SPAN},
    '{ROW_REG,  REG_COLUMNS, 6'd1,  63'd0,      1'b0, NO_SPAN},
    '{ROW_REG,  REG_ROWS,    6'd63, 63'd0,      1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  ALL_SITES,  1'b1, '{1'b0, 60'd1, 6'd63, 1'b1}},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h7FFF_FFFF_7FFF_FFFF, 1'b0, NO_SPAN},
    '{ROW_REG,  REG_COLUMNS, 6'd63, 63'd0,      1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  ALL_SITES,  1'b1, OVERSIZE},
    '{ROW_REG,  REG_COLUMNS, 6'd0,  63'd0,      1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  ALL_SITES,  1'b1, NO_SPAN},
    '{ROW_REG,  REG_COLUMNS, 6'd8,  63'd0,      1'b0, NO_SPAN},
    '{ROW_REG,  REG_ROWS,    6'd8,  63'd0,      1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h5555_AAAA_1234_5678, 1'b1, OVERSIZE},
    '{ROW_REG,  REG_ROWS,    6'd0,  63'd0,      1'b0, NO_SPAN},
    '{ROW_REG,  REG_SPARE_A, 6'd63, 63'd0,      1'b0, NO_SPAN},
    '{ROW_REG,  REG_SPARE_B, 6'd21, 63'd0,      1'b0, NO_SPAN},
    '{ROW_MASK, REG_COLUMNS, 6'd0,  63'h2AAA_5555_0F0F_F0F0, 1'b0, NO_SPAN},
    '{ROW_REG,  REG_COLUMNS, 6'd7,  63'd0,      1'b0, NO_SPAN}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [DIM_W-1:0]       cfg_data_i = '0;

  int unsigned  src_idle = 13;
  int unsigned  sink_idle = 58;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  grid_cols = COLUMNS_RESET;
  int unsigned  grid_rows = ROWS_RESET;
  logic [TALLY_W-1:0] tally_hist [HIST_DEPTH];
  span_result_t expected_q [$];

  grid_spanning_cluster_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  // Flood fill from the occupied top row; also updates the histogram copy.
  function automatic span_result_t evaluate_mask(input logic [OCC_W-1:0] mask);
    span_result_t r;
    int unsigned  sites;
    int unsigned  k;
    int unsigned  i;
    logic [63:0]  grid, occ, top, bottom, left_e, right_e, reach, prev;
    r = '0;
    sites = grid_cols * grid_rows;
    if (sites > MAX_SITES) begin
      r.size_error = 1'b1;
      return r;
    end
    if (sites == 0) begin
      r.tally = tally_hist[0];
      return r;
    end
    grid = (64'd1 << sites) - 64'd1;
    occ = {1'b0, mask} & grid;
    k = $countones(occ);
    top = (64'd1 << grid_cols) - 64'd1;
    bottom = top << ((grid_rows - 1) * grid_cols);
    left_e = '0;
    right_e = '0;
    for (i = 0; i < sites; i += grid_cols) begin
      left_e[i] = 1'b1;
      right_e[i + grid_cols - 1] = 1'b1;
    end
    reach = occ & top;
    do begin
      prev = reach;
      reach = (prev | ((prev & ~right_e) << 1) | ((prev & ~left_e) >> 1)
               | (prev << grid_cols) | (prev >> grid_cols)) & occ;
    end while (reach != prev);
    r.spans = |(reach & bottom);
    if (r.spans && tally_hist[k] != TALLY_MAX) begin
      tally_hist[k] = tally_hist[k] + 1'b1;
    end
    r.occupied = CNT_W'(k);
    r.tally = tally_hist[k];
    return r;
  endfunction

  function automatic logic [OCC_W-1:0] random_mask();
    logic [OCC_W-1:0] m;
    int unsigned      density;
    m = OCC_W'({$urandom(), $urandom()});
    if ($urandom_range(3) != 0) begin
      density = $urandom_range(95, 35);
      for (int b = 0; b < OCC_W; b++) begin
        m[b] = ($urandom_range(99) < density);
      end
    end
    return m;
  endfunction

  task automatic send_mask(input logic [OCC_W-1:0] mask, input logic typed,
                           input span_result_t want);
    span_result_t predicted;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, mask};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = evaluate_mask(mask);
    expected_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_COLUMNS: grid_cols = val;
      REG_ROWS:    grid_rows = val;
      default: ;
    endcase
  endtask

  task automatic random_config();
    int unsigned sel, c, r;
    sel = $urandom_range(99);
    if (sel < 70) begin
      c = $urandom_range(63, 1);
      r = $urandom_range(63 / c, 1);
    end else if (sel < 80) begin
      c = $urandom_range(63, 2);
      r = $urandom_range(63, 63 / c + 1);
    end else if (sel < 86) begin
      c = $urandom_range(63);
      r = 0;
      if ($urandom_range(1) == 1) begin
        r = c;
        c = 0;
      end
    end else begin
      case ($urandom_range(3))
        0: begin c = 63; r = 1; end
        1: begin c = 1; r = 63; end
        2: begin c = 7; r = 9; end
        default: begin c = 63; r = 63; end
      endcase
    end
    wait_idle();
    if ($urandom_range(9) == 0) begin
      write_reg(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom()));
    end
    write_reg(REG_COLUMNS, DIM_W'(c));
    write_reg(REG_ROWS, DIM_W'(r));
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    span_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.spans      = m_axis_tdata[0];
      got.occupied   = m_axis_tdata[6:1];
      got.tally      = m_axis_tdata[66:7];
      got.size_error = m_axis_tdata[67];
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected response: spans %0b sites %0d tally %0d size_error %0b",
                   got.spans, got.occupied, got.tally, got.size_error);
        end
      end else begin
        want = expected_q.pop_front();
        if (got.spans !== want.spans || got.occupied !== want.occupied ||
            got.tally !== want.tally || got.size_error !== want.size_error) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("mismatch: expected spans %0b sites %0d tally %0d size_error %0b",
                     want.spans, want.occupied, want.tally, want.size_error);
            $display("          actual   spans %0b sites %0d tally %0d size_error %0b",
                     got.spans, got.occupied, got.tally, got.size_error);
          end
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned group;
    foreach (tally_hist[h]) tally_hist[h] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].reg_val);
      end else begin
        cfg_valid_i <= 1'b0;
        send_mask(DIR_TABLE[i].mask, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      end
    end
    wait_idle();
    write_reg(REG_ROWS, DIM_W'(9));
    cfg_valid_i <= 1'b0;
    send_mask(ALL_SITES, 1'b1, '{1'b0, 60'd2, 6'd63, 1'b1});

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle = 13; sink_idle = 58; end
        1: begin src_idle = 58; sink_idle = 13; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_config();
        group = $urandom_range(30, 8);
        repeat (group) begin
          send_mask(random_mask(), 1'b0, NO_SPAN);
          sent++;
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    fail_count += expected_q.size();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
